/* hw/rtl/drfl_pkg.sv */
package drfl_pkg;

    localparam int unsigned DEPTH_DEFAULT = 1024;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned DATE_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int unsigned AMOUNT_W = 32;
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned PROD_W   = 62;
    localparam int unsigned FRAC_W   = 16;

    localparam logic [YEAR_W-1:0]   MIN_YEAR     = 12'd2009;
    localparam logic [AMOUNT_W-1:0] AMOUNT_LIMIT = 32'd1000 << FRAC_W;
    localparam logic [YEAR_W-1:0]   RECIP_25     = 12'd2622;
    localparam logic [YEAR_W-1:0]   CENTURY_DIV  = 12'd25;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_DATE  = 3'd1,
        ST_NEGATIVE  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_NO_ENTRY  = 3'd4,
        ST_STORED    = 3'd5,
        ST_FULL      = 3'd6,
        ST_CLEARED   = 3'd7
    } status_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic step;
        logic mul;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic need_search;
        logic search_done;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/drfl_if.sv */
interface drfl_req_if import drfl_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [YEAR_W-1:0]          year;
    logic [MONTH_W-1:0]         month;
    logic [DAY_W-1:0]           day;
    logic signed [AMOUNT_W-1:0] amount;
    logic [RATE_W-1:0]          rate;

    modport source (output valid, opcode, year, month, day, amount, rate, input ready);
    modport sink (input valid, opcode, year, month, day, amount, rate, output ready);
endinterface

interface drfl_rsp_if import drfl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [YEAR_W-1:0]  match_year;
    logic [MONTH_W-1:0] match_month;
    logic [DAY_W-1:0]   match_day;
    logic [PROD_W-1:0]  product;

    modport source (output valid, status, match_year, match_month, match_day, product,
                    input ready);
    modport sink (input valid, status, match_year, match_month, match_day, product,
                  output ready);
endinterface

/* hw/rtl/drfl_ram.sv */
module drfl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/drfl_ctrl.sv */
module drfl_ctrl import drfl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SEARCH = 5'b00100,
        S_MUL    = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                priority if (sts.drop)
                    state_next = S_IDLE;
                else if (sts.need_search)
                    state_next = S_SEARCH;
                else
                    state_next = S_RESP;
            end
            S_SEARCH:
            begin
                cmd.step = 1'b1;
                if (sts.search_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("response loaded while output register busy");

    a_search_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && sts.search_done |=> cmd.mul)
        else $error("finished search not followed by multiply");

endmodule

/* hw/rtl/drfl_dp.sv */
module drfl_dp import drfl_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [1:0]                 opcode,
    input  logic [YEAR_W-1:0]          year,
    input  logic [MONTH_W-1:0]         month,
    input  logic [DAY_W-1:0]           day,
    input  logic signed [AMOUNT_W-1:0] amount,
    input  logic [RATE_W-1:0]          rate,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output logic [2:0]                 status,
    output logic [YEAR_W-1:0]          match_year,
    output logic [MONTH_W-1:0]         match_month,
    output logic [DAY_W-1:0]           match_day,
    output logic [PROD_W-1:0]          product
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    opcode_t             op_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [RATE_W-1:0]   rate_reg;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [DATE_W-1:0]   last_date_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [AW-1:0]       mid_reg;
    logic [DATE_W-1:0]   hit_date_reg;
    logic [RATE_W-1:0]   hit_rate_reg;
    logic                found_reg;
    status_t             status_reg;
    status_t             status_next;
    logic [PROD_W-1:0]   prod_reg;

    logic                rsp_valid_reg;
    status_t             out_status_reg;
    logic [DATE_W-1:0]   out_date_reg;
    logic [PROD_W-1:0]   out_prod_reg;

    logic [DATE_W-1:0]   key;
    logic [DATE_W-1:0]   rd_date;
    logic [RATE_W-1:0]   rd_rate;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;

    logic [2*YEAR_W-1:0] y_mul;
    logic [7:0]          y_quot;
    logic [YEAR_W-1:0]   y_rem25;
    logic                leap;
    logic                month_ok;
    logic [DAY_W-1:0]    last_day;
    logic                date_ok;
    logic                full;
    logic                append_order_bad;
    logic                amount_ok;

    logic                data_le;
    logic [CW-1:0]       lo_step;
    logic [CW-1:0]       hi_step;
    logic [CW:0]         sum_step;
    logic [AW-1:0]       mid_step;
    logic [CW-1:0]       mid_init;
    logic [63:0]         prod_full;

    assign key = {year_reg, month_reg, day_reg};

    // century test by reciprocal: year mod 25 for a 12-bit year
    assign y_mul   = year_reg * RECIP_25;
    assign y_quot  = y_mul[2*YEAR_W-1:16];
    assign y_rem25 = year_reg - YEAR_W'(y_quot) * CENTURY_DIV;
    assign leap    = (year_reg[1:0] == 2'd0) &&
                     ((y_rem25 != '0) || (year_reg[3:0] == 4'd0));

    always_comb
    begin
        month_ok = 1'b1;
        last_day = 5'd31;
        unique case (month_reg)
            4'd2:
            begin
                last_day = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                last_day = 5'd30;
            end
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
            begin
                last_day = 5'd31;
            end
            default:
            begin
                month_ok = 1'b0;
            end
        endcase
    end

    assign date_ok   = (year_reg >= MIN_YEAR) && (day_reg != '0) && month_ok &&
                       (day_reg <= last_day);
    assign amount_ok = !amount_reg[AMOUNT_W-1] && (amount_reg <= AMOUNT_LIMIT);
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign append_order_bad = (count_reg != '0) && (key <= last_date_reg);

    assign wr_en   = cmd.check && (op_reg == OP_APPEND) && !full && !append_order_bad;
    assign wr_addr = AW'(count_reg);

    // one probe per cycle: compare last read, issue next address
    assign data_le  = (rd_date <= key);
    assign lo_step  = data_le ? (CW'(mid_reg) + 1'b1) : lo_reg;
    assign hi_step  = data_le ? hi_reg : CW'(mid_reg);
    assign sum_step = {1'b0, lo_step} + {1'b0, hi_step};
    assign mid_step = AW'(sum_step >> 1);
    assign mid_init = count_reg >> 1;
    assign rd_addr  = cmd.check ? AW'(mid_init) : mid_step;

    assign prod_full = amount_reg * hit_rate_reg;

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        unique case (op_reg)
            OP_CLEAR:
            begin
                count_next  = '0;
                status_next = ST_CLEARED;
            end
            OP_APPEND:
            begin
                priority if (full)
                    status_next = ST_FULL;
                else if (append_order_bad)
                    status_next = ST_BAD_DATE;
                else
                begin
                    count_next  = count_reg + 1'b1;
                    status_next = ST_STORED;
                end
            end
            OP_QUERY:
            begin
                priority if (!date_ok)
                    status_next = ST_BAD_DATE;
                else if (amount_reg[AMOUNT_W-1])
                    status_next = ST_NEGATIVE;
                else if (amount_reg > AMOUNT_LIMIT)
                    status_next = ST_TOO_LARGE;
                else
                    status_next = ST_NO_ENTRY;
            end
            OP_NONE:
            begin
                status_next = status_reg;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_comb
    begin
        sts             = '0;
        sts.drop        = (op_reg == OP_NONE);
        sts.need_search = (op_reg == OP_QUERY) && date_ok && amount_ok && (count_reg != '0);
        sts.search_done = (lo_step >= hi_step);
        sts.out_free    = !rsp_valid_reg || rsp_ready;
    end

    drfl_ram #(
        .WIDTH (DATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_date_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key),
        .rd_addr (rd_addr),
        .rd_data (rd_date)
    );

    drfl_ram #(
        .WIDTH (RATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rate_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rate_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_rate)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            year_reg   <= year;
            month_reg  <= month;
            day_reg    <= day;
            amount_reg <= amount;
            rate_reg   <= rate;
        end
        if (wr_en)
        begin
            last_date_reg <= key;
        end
        if (cmd.check)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            mid_reg <= rd_addr;
        end
        if (cmd.step)
        begin
            lo_reg  <= lo_step;
            hi_reg  <= hi_step;
            mid_reg <= rd_addr;
            if (data_le)
            begin
                hit_date_reg <= rd_date;
                hit_rate_reg <= rd_rate;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(prod_full >> FRAC_W);
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_date_reg   <= (found_reg && (status_reg == ST_OK)) ? hit_date_reg : '0;
            out_prod_reg   <= (found_reg && (status_reg == ST_OK)) ? prod_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_NONE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            status_reg    <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg <= opcode_t'(opcode);
            end
            if (cmd.check)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
                found_reg  <= 1'b0;
            end
            if (cmd.step && data_le)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.mul && found_reg)
            begin
                status_reg <= ST_OK;
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = out_status_reg;
    assign match_year  = out_date_reg[DATE_W-1 -: YEAR_W];
    assign match_month = out_date_reg[DAY_W +: MONTH_W];
    assign match_day   = out_date_reg[DAY_W-1:0];
    assign product     = out_prod_reg;

    a_step_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (lo_reg < hi_reg))
        else $error("search step with empty window");

    a_ok_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && (status_reg == ST_OK) |-> found_reg)
        else $error("ok response without a matched entry");

    a_append_bumps: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("stored entry did not advance the fill count");

endmodule

/* hw/rtl/dated_rate_floor_lookup.sv */
// Dated rate table with floor lookup. Entries (date, Q16.16 rate) are appended in strictly
// ascending date order; a query checks its date and Q16.16 amount (0 to 1000) and returns
// amount times the rate of the latest entry dated on or before the query date, as Q.16.
// One transaction is worked on at a time; the next request is taken while a response
// still waits on the output register. Clear, append and rejected queries go from the check
// straight to the response state. A searched query runs the binary search loop, which
// reads one table entry per cycle from the registered-read table memory, and then a
// multiply step before its response is loaded into the free output register.
module dated_rate_floor_lookup import drfl_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    drfl_req_if.sink  request,
    drfl_rsp_if.source response
);

    cmd_t cmd;
    sts_t sts;

    drfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    drfl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (request.opcode),
        .year        (request.year),
        .month       (request.month),
        .day         (request.day),
        .amount      (request.amount),
        .rate        (request.rate),
        .rsp_ready   (response.ready),
        .rsp_valid   (response.valid),
        .status      (response.status),
        .match_year  (response.match_year),
        .match_month (response.match_month),
        .match_day   (response.match_day),
        .product     (response.product)
    );

endmodule
